// ===== hw/rtl/bb3_pkg.sv =====
package bb3_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 4096;

   // Column index into a line store, and a row counter that also covers
   // the two flush rows after the last row of pixels.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int WCFG_W = 10;
   localparam int HCFG_W = 13;
   // Clamped sizes: width up to MAX_WIDTH, height up to MAX_HEIGHT.
   localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
   localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);

   localparam int APB_AW = 3;
   localparam int APB_DW = 32;

   // Register index, taken from paddr[2].
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(512);
   localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(512);

   // A sum of nine 8-bit channels, and floor(sum / 9) as a multiply by a
   // rounded-up reciprocal; exact for every sum below 2**RECIP_SHIFT.
   localparam int SUM_W       = 12;
   localparam int RECIP_SHIFT = 15;
   localparam logic [SUM_W-1:0] RECIP_9 = SUM_W'(((1 << RECIP_SHIFT) + 8) / 9);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [WEFF_W-1:0] width;
      logic [HEFF_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      pixel_type        upper;
      pixel_type        middle;
   } line_wr_type;

   function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
      logic [2*SUM_W-1:0] prod;
      prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP_9);
      return prod[RECIP_SHIFT +: 8];
   endfunction

endpackage

// ===== hw/rtl/bb3_if.sv =====
interface bb3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic       drain;

   modport source (output valid, red_in, green_in, blue_in, drain, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, drain, output ready);
endinterface

interface bb3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ===== hw/rtl/bb3_csr.sv =====
module bb3_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [bb3_pkg::APB_AW-1:0] paddr,
   input  logic [bb3_pkg::APB_DW-1:0] pwdata,
   output logic [bb3_pkg::APB_DW-1:0] prdata,
   output logic                      pready,
   output bb3_pkg::cfg_type          cfg
);
   import bb3_pkg::*;

   logic [WCFG_W-1:0] width_ff, width_in;
   logic [HCFG_W-1:0] height_ff, height_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_IMAGE_WIDTH:  width_in  = pwdata[WCFG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[HCFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_IMAGE_WIDTH:  prdata = APB_DW'(width_ff);
         REG_IMAGE_HEIGHT: prdata = APB_DW'(height_ff);
         default:          prdata = '0;
      endcase
   end

   // Effective sizes, clamped to the range the datapath supports.
   always_comb begin
      if (width_ff < WCFG_W'(3)) begin
         cfg.width = WEFF_W'(3);
      end else if (width_ff > WCFG_W'(MAX_WIDTH)) begin
         cfg.width = WEFF_W'(MAX_WIDTH);
      end else begin
         cfg.width = WEFF_W'(width_ff);
      end
      if (height_ff < HCFG_W'(3)) begin
         cfg.height = HEFF_W'(3);
      end else if (height_ff > HCFG_W'(MAX_HEIGHT)) begin
         cfg.height = HEFF_W'(MAX_HEIGHT);
      end else begin
         cfg.height = HEFF_W'(height_ff);
      end
   end

endmodule

// ===== hw/rtl/bb3_line_mem.sv =====
module bb3_line_mem (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [bb3_pkg::COL_W-1:0] rd_addr,
   input  bb3_pkg::line_wr_type     wr,
   output bb3_pkg::pixel_type       rd_upper,
   output bb3_pkg::pixel_type       rd_middle
);
   import bb3_pkg::*;

   pixel_type upper_mem  [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];

   pixel_type upper_rd_ff, middle_rd_ff;
   pixel_type fwd_upper_ff, fwd_middle_ff;
   logic      fwd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         upper_mem[wr.addr]  <= wr.upper;
         middle_mem[wr.addr] <= wr.middle;
      end
      if (rd_en) begin
         upper_rd_ff  <= upper_mem[rd_addr];
         middle_rd_ff <= middle_mem[rd_addr];
      end
   end

   // A read of the entry being written in the same cycle takes the new data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_ff        <= wr.en && (wr.addr == rd_addr);
         fwd_upper_ff  <= wr.upper;
         fwd_middle_ff <= wr.middle;
      end
   end

   assign rd_upper  = fwd_ff ? fwd_upper_ff  : upper_rd_ff;
   assign rd_middle = fwd_ff ? fwd_middle_ff : middle_rd_ff;

endmodule

// ===== hw/rtl/bb3_mean.sv =====
module bb3_mean (
   input  bb3_pkg::pixel_type [8:0] taps,
   output bb3_pkg::pixel_type       mean
);
   import bb3_pkg::*;

   logic [SUM_W-1:0] sum [3];
   logic [23:0]      res;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
         for (int k = 0; k < 9; k++) begin
            sum[ch] = sum[ch] + SUM_W'(taps[k][8*ch +: 8]);
         end
         res[8*ch +: 8] = div9(sum[ch]);
      end
   end

   assign mean = pixel_type'(res);

endmodule

// ===== hw/rtl/box_blur_3x3_raster.sv =====
// 3x3 box blur over an RGB raster stream. Each word on req_chan is one
// pixel in raster order; each interior pixel comes out on rsp_chan as the
// per-channel floor of the mean of its 3x3 neighborhood, while pixels on
// the first and last row and column pass through unchanged. Results lag
// their pixels by image_width + 1 words, so after the last pixel of a
// frame the source sends image_width + 1 words with drain set to flush
// the rest; frame_end marks the result of the frame's last pixel, and the
// next frame starts right after the flush. The block takes one word per
// clock when the sink keeps up: every pixel is read from and written back
// to two line stores (512 x 24 bits each, one read and one write port) in
// a read-modify-write across the second stage; a result is registered as
// the last word of its window retires. The line stores need no clearing
// after reset. image_width (offset 0, clamped to 3..512) and image_height
// (offset 4, clamped to 3..4096) may be written only while the block is
// idle.
module box_blur_3x3_raster (
   input  logic                       clock,
   input  logic                       reset,
   bb3_req_if.sink                    req_chan,
   bb3_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bb3_pkg::APB_AW-1:0] paddr,
   input  logic [bb3_pkg::APB_DW-1:0] pwdata,
   output logic [bb3_pkg::APB_DW-1:0] prdata,
   output logic                       pready
);
   import bb3_pkg::*;

   cfg_type     cfg;
   line_wr_type line_wr;
   pixel_type   rd_upper, rd_middle;
   pixel_type   cur_px;
   pixel_type   mean_px;
   pixel_type   res_px;

   // Position of the next word in the frame, including the flush rows.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WEFF_W-1:0] col_next;

   // Second stage: the word whose line store data is being read.
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   pixel_type        s1_px_ff;
   logic             s1_adv;
   logic             accept;

   // The two previous column triples; index 1 is the pixel under the
   // window center and becomes the result on the image border.
   pixel_type [5:0] win_ff;

   logic             has_result;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;
   logic             interior;
   logic             last_pixel;

   logic             out_valid_ff, out_valid_in;
   pixel_type        out_px_ff;
   logic             out_end_ff;

   bb3_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The second stage moves on whenever the output register is free or
   // emptying, and a new word can enter when the second stage is empty or moves on.
   assign s1_adv          = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !s1_valid_ff || s1_adv;
   assign accept          = req_chan.valid && req_chan.ready;

   // Drain words are stored as black pixels.
   assign cur_px = req_chan.drain ? '0
                 : pixel_type'({req_chan.red_in, req_chan.green_in, req_chan.blue_in});

   // Position counters advance when a word is accepted. After the single
   // word of the second flush row the position returns to the frame start.
   always_comb begin
      col_next = WEFF_W'(col_ff) + WEFF_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (row_ff >= ROW_W'(cfg.height) + ROW_W'(1)) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= cfg.width) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         s1_px_ff  <= cur_px;
      end
   end

   // Read the column at acceptance, write it back when the word retires:
   // the middle line moves up and the new pixel becomes the middle line.
   assign line_wr.en     = s1_adv;
   assign line_wr.addr   = s1_col_ff;
   assign line_wr.upper  = rd_middle;
   assign line_wr.middle = s1_px_ff;

   bb3_line_mem u_line_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (col_ff),
      .wr        (line_wr),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle)
   );

   bb3_mean u_mean (
      .taps ({win_ff, rd_upper, rd_middle, s1_px_ff}),
      .mean (mean_px)
   );

   // The result belongs to the pixel width + 1 words back, which is the
   // center of the current window.
   always_comb begin
      has_result = (s1_row_ff >= ROW_W'(2))
                || ((s1_row_ff == ROW_W'(1)) && (s1_col_ff != '0));
      if (s1_col_ff != '0) begin
         out_row = s1_row_ff - ROW_W'(1);
         out_col = s1_col_ff - COL_W'(1);
      end else begin
         out_row = s1_row_ff - ROW_W'(2);
         out_col = COL_W'(cfg.width - WEFF_W'(1));
      end
      interior = (out_row >= ROW_W'(1))
              && (out_row <= ROW_W'(cfg.height) - ROW_W'(2))
              && (out_col != '0)
              && (WEFF_W'(out_col) <= cfg.width - WEFF_W'(2));
      last_pixel = (out_row == ROW_W'(cfg.height) - ROW_W'(1))
                && (WEFF_W'(out_col) == cfg.width - WEFF_W'(1));
      res_px = interior ? mean_px : win_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff[5:3] <= win_ff[2:0];
         win_ff[0]   <= rd_upper;
         win_ff[1]   <= rd_middle;
         win_ff[2]   <= s1_px_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && has_result) begin
         out_px_ff  <= res_px;
         out_end_ff <= last_pixel;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.red_out   = out_px_ff.red;
   assign rsp_chan.green_out = out_px_ff.green;
   assign rsp_chan.blue_out  = out_px_ff.blue;
   assign rsp_chan.frame_end = out_end_ff;

endmodule

// ===== hw/rtl/bb3_checker.sv =====
module bb3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [24:0] rsp_word,
   input logic        pready
);

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A result that is offered is held until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
      else $error("result dropped or changed while stalled");

   // A result that appears after an empty cycle comes from a word that was
   // accepted and then left the second stage without stalling.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !$past(reset)) |-> $past(req_valid && req_ready, 2))
      else $error("result without an accepted word");

   // The input side keeps taking words while the output is drained.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready && !rsp_valid) |-> req_ready)
      else $error("input stalled with an empty output");

   a_pready: assert property (@(posedge clock) pready)
      else $error("configuration port not ready");

endmodule

bind box_blur_3x3_raster bb3_checker u_bb3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  ({rsp_chan.red_out, rsp_chan.green_out, rsp_chan.blue_out,
                rsp_chan.frame_end}),
   .pready    (pready)
);
